/* hw/rtl/text_cell_pixel_renderer_top_macros.svh */
// Assertion macros shared by the renderer checker.
// Depends on nothing; included by tcpr_checker.sv.
`ifndef TEXT_CELL_PIXEL_RENDERER_TOP_MACROS_SVH
`define TEXT_CELL_PIXEL_RENDERER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TCPR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tcpr assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define TCPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tcpr assertion failed");

`endif

/* hw/rtl/tcpr_pkg.sv */
// Package for the text cell pixel renderer: screen geometry, codes, payload types.
// Depends on nothing; used by every module of the renderer.
`timescale 1ns / 1ps

package tcpr_pkg;

  // Screen and font geometry
  localparam int unsigned SCREEN_WIDTH  = 400;
  localparam int unsigned SCREEN_HEIGHT = 240;
  localparam int unsigned GLYPH_BYTES   = 760;
  localparam int unsigned GLYPH_AW      = $clog2(GLYPH_BYTES);

  // Field and internal widths
  localparam int unsigned POS_W   = 12;
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned ADDR_CW = 12;
  localparam int unsigned OFF_W   = 19;
  localparam int unsigned COLOR_W = 24;

  // Cursor steps
  localparam logic [POS_W-1:0] HOME_POS  = POS_W'(10);
  localparam logic [5:0]       LINE_STEP = 6'd10;
  localparam logic [5:0]       CELL_STEP = 6'd8;
  localparam logic [5:0]       TAB_STEP  = 6'd32;

  // Character codes
  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_FIRST   = 8'h21;
  localparam logic [7:0] CHR_LAST    = 8'h7E;
  localparam logic [6:0] CHR_BASE    = 7'h20;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_EOM  = 2'd1,
    CMD_FONT = 2'd2,
    CMD_HOME = 2'd3
  } tcpr_cmd_e;

  typedef struct packed {
    tcpr_cmd_e         cmd;
    logic [7:0]        char_code;
    logic [ADDR_W-1:0] font_index;
    logic [7:0]        font_byte;
  } tcpr_in_t;

  typedef struct packed {
    logic [OFF_W-1:0]   pixel_offset;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } tcpr_out_t;

  // Add a small step to a cursor coordinate, saturating at the top code
  function automatic logic [POS_W-1:0] pos_add(logic [POS_W-1:0] a, logic [5:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {{(POS_W-5){1'b0}}, b};
    return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
  endfunction

endpackage

/* hw/rtl/tcpr_glyph_mem.sv */
// Glyph row store: one write port, one registered read port, range-checked.
// Depends on tcpr_pkg.
`timescale 1ns / 1ps

module tcpr_glyph_mem
  import tcpr_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] mem [GLYPH_BYTES];

  logic [ADDR_CW-1:0] wr_ext;
  logic [ADDR_CW-1:0] rd_ext;
  logic               wr_ok;
  logic               rd_ok;
  logic [7:0]         rd_q;
  logic               rd_ok_q;

  // Widen addresses for the range check
  assign wr_ext = ADDR_CW'(wr_addr_i);
  assign rd_ext = ADDR_CW'(rd_addr_i);
  assign wr_ok  = wr_ext < ADDR_CW'(GLYPH_BYTES);
  assign rd_ok  = rd_ext < ADDR_CW'(GLYPH_BYTES);

  // Write in range; read data is registered
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_ok) begin
      mem[wr_ext[GLYPH_AW-1:0]] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q    <= mem[rd_ext[GLYPH_AW-1:0]];
      rd_ok_q <= rd_ok;
    end
  end

  // Out-of-range reads return an empty row
  assign rd_data_o = rd_ok_q ? rd_q : 8'h00;

endmodule

/* hw/rtl/text_cell_pixel_renderer_top.sv */
// Channel | Dir | Handshake              | Payload
// in      | in  | in_valid_i / in_stall_o  | tcpr_in_t  in_data_i
// out     | out | out_valid_o / out_stall_i| tcpr_out_t out_data_o
// cfg     | in  | cfg_valid_i / cfg_ready_o| glyph color, cfg_data_i
//
// Commands other than a printable character leave the block idle, ready for the next.
// A printable character passes a setup state, then, per visible cell row, one glyph
// memory read and one pixel per cycle while the output is not stalled.
// The single read port of the glyph memory sets the one-row-per-read pace.
// Reset restores the cursor to (10,10) and the color to white; glyph rows
// hold nothing until loaded. A stalled output holds the pixel sequencer.
`timescale 1ns / 1ps

module text_cell_pixel_renderer_top
  import tcpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcpr_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcpr_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COLOR_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_READ  = 4'b0100,
    S_EMIT  = 4'b1000
  } tcpr_state_e;

  localparam logic [OFF_W-1:0] COL_STRIDE = OFF_W'(3 * SCREEN_HEIGHT);
  localparam logic [OFF_W-1:0] ROW_STRIDE = OFF_W'(3);

  tcpr_state_e        state_q, state_d;
  logic [POS_W-1:0]   col_q, col_d;
  logic [POS_W-1:0]   row_q, row_d;
  logic [6:0]         code_q, code_d;
  logic [2:0]         ri_q, ri_d;
  logic [2:0]         ci_q, ci_d;
  logic [2:0]         imax_q, imax_d;
  logic [2:0]         jmax_q, jmax_d;
  logic [OFF_W-1:0]   row_off_q, row_off_d;
  logic [OFF_W-1:0]   pix_off_q, pix_off_d;
  logic [COLOR_W-1:0] color_q;
  logic               out_valid_q, out_valid_d;
  tcpr_out_t          out_q, out_d;

  logic               in_accept;
  logic               out_free;
  logic               printable;
  logic               mem_wr_en;
  logic               mem_rd_en;
  logic [ADDR_W-1:0]  mem_rd_addr;
  logic [7:0]         mem_rd_data;
  logic [POS_W-1:0]   eom_row;
  logic [POS_W-1:0]   rows_left;
  logic [POS_W-1:0]   cols_left;
  logic               cell_visible;
  logic [31:0]        col_mul;
  logic [POS_W-1:0]   row_flip;
  logic [OFF_W-1:0]   cell_off;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign printable = (in_data_i.char_code >= CHR_FIRST) && (in_data_i.char_code <= CHR_LAST);
  assign eom_row   = pos_add(row_q, LINE_STEP);

  // Cell geometry from the settled cursor
  assign rows_left    = POS_W'(SCREEN_HEIGHT) - row_q;
  assign cols_left    = POS_W'(SCREEN_WIDTH) - col_q;
  assign cell_visible = (row_q < POS_W'(SCREEN_HEIGHT)) && (col_q < POS_W'(SCREEN_WIDTH));
  assign col_mul      = 32'(col_q) * 32'(COL_STRIDE);
  assign row_flip     = POS_W'(SCREEN_HEIGHT - 1) - row_q;
  assign cell_off     = col_mul[OFF_W-1:0] + OFF_W'({row_flip, 1'b0}) + OFF_W'(row_flip);

  assign mem_rd_addr = {code_q - CHR_BASE, ri_q};

  tcpr_glyph_mem u_glyph_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (in_data_i.font_index),
    .wr_data_i (in_data_i.font_byte),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Sequence commands and walk the pixels of a cell
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    code_d      = code_q;
    ri_d        = ri_q;
    ci_d        = ci_q;
    imax_d      = imax_q;
    jmax_d      = jmax_q;
    row_off_d   = row_off_q;
    pix_off_d   = pix_off_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_data_i.cmd)
            CMD_CHAR: begin
              if (in_data_i.char_code == CHR_NEWLINE) begin
                col_d = HOME_POS;
                row_d = eom_row;
              end else if (in_data_i.char_code == CHR_SPACE) begin
                col_d = pos_add(col_q, CELL_STEP);
              end else if (in_data_i.char_code == CHR_TAB) begin
                col_d = pos_add(col_q, TAB_STEP);
              end else if (printable) begin
                // Wrap before drawing when the cell would run off the line
                if (col_q > POS_W'(SCREEN_WIDTH - 8)) begin
                  col_d = HOME_POS;
                  row_d = eom_row;
                end
                code_d  = in_data_i.char_code[6:0];
                state_d = S_SETUP;
              end
            end
            CMD_EOM: begin
              col_d = HOME_POS;
              row_d = (eom_row > POS_W'(SCREEN_HEIGHT - 10)) ? HOME_POS : eom_row;
            end
            CMD_FONT: begin
              mem_wr_en = 1'b1;
            end
            CMD_HOME: begin
              col_d = HOME_POS;
              row_d = HOME_POS;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SETUP: begin
        ri_d      = 3'd0;
        ci_d      = 3'd0;
        imax_d    = (rows_left >= POS_W'(8)) ? 3'd7 : (rows_left[2:0] - 3'd1);
        jmax_d    = (cols_left >= POS_W'(8)) ? 3'd7 : (cols_left[2:0] - 3'd1);
        row_off_d = cell_off;
        pix_off_d = cell_off;
        if (cell_visible) begin
          state_d = S_READ;
        end else begin
          col_d   = pos_add(col_q, CELL_STEP);
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        mem_rd_en = 1'b1;
        ci_d      = 3'd0;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.pixel_offset     = pix_off_q;
          out_d.pixel_color      = mem_rd_data[3'd7 - ci_q] ? color_q : '0;
          out_d.last_pixel       = (ci_q == jmax_q) && (ri_q == imax_q);
          if (ci_q == jmax_q) begin
            if (ri_q == imax_q) begin
              col_d   = pos_add(col_q, CELL_STEP);
              state_d = S_IDLE;
            end else begin
              // Next row sits one pixel lower in the rotated layout
              ri_d      = ri_q + 3'd1;
              row_off_d = row_off_q - ROW_STRIDE;
              pix_off_d = row_off_q - ROW_STRIDE;
              state_d   = S_READ;
            end
          end else begin
            ci_d      = ci_q + 3'd1;
            pix_off_d = pix_off_q + COL_STRIDE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= HOME_POS;
      row_q       <= HOME_POS;
      color_q     <= COLOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_data_i;
      end
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    ri_q      <= ri_d;
    ci_q      <= ci_d;
    imax_q    <= imax_d;
    jmax_q    <= jmax_d;
    row_off_q <= row_off_d;
    pix_off_q <= pix_off_d;
    out_q     <= out_d;
  end

endmodule

/* hw/rtl/tcpr_checker.sv */
// Port-level checker for the renderer, bound to the top level.
// Depends on tcpr_pkg and text_cell_pixel_renderer_top_macros.svh.
`timescale 1ns / 1ps
`include "text_cell_pixel_renderer_top_macros.svh"

module tcpr_checker
  import tcpr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input tcpr_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input tcpr_out_t out_data_o
);

  // Hold a stalled pixel transaction
  `TCPR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Return to accepting after any command other than a character
  `TCPR_ASSERT_NEXT(a_quick_cmd, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.cmd != CMD_CHAR, !in_stall_o)

  // Pixels appear only while a cell is being drawn
  `TCPR_ASSERT_NOW(a_pix_in_cell, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind text_cell_pixel_renderer_top tcpr_checker u_tcpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
